// ===== hw/rtl/scbw_pkg.sv =====
// Shared types and constants of the sprite collision buffer writer.
// No dependencies; used by scbw_depository and sprite_collision_buffer_writer.
package scbw_pkg;

    // Item kinds
    localparam logic [1:0] KIND_NEW_LINE     = 2'd0;
    localparam logic [1:0] KIND_PIXEL        = 2'd1;
    localparam logic [1:0] KIND_FLUSH        = 2'd2;
    localparam logic [1:0] KIND_DEPOSIT_READ = 2'd3;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_COLL_NUMBER      = 2'd0;
    localparam logic [1:0] REG_COLLIDING_COLORS = 2'd1;
    localparam logic [1:0] REG_DEPOSIT_ENABLE   = 2'd2;

    localparam int          ADDR_W      = 4;
    localparam int          LINE_PIXELS = 1024;
    localparam logic [31:0] NIBBLE_MASK = 32'h0000_000f;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] line_address;
        logic [9:0]  hpos;
        logic [3:0]  pixel;
        logic [31:0] read_word;
    } item_t;

    typedef struct packed {
        logic        write_valid;
        logic [31:0] write_mask;
        logic [15:0] write_address;
        logic [15:0] write_data;
        logic        highest_valid;
        logic [3:0]  highest_collision;
    } result_t;

endpackage

// ===== hw/rtl/scbw_depository.sv =====
// Collision depository: per-nibble running maximum of words read back.
// Depends on scbw_pkg only for the common import convention.
module scbw_depository
    import scbw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        update,
    input  logic [31:0] read_word,
    output logic [3:0]  highest
);

    logic [31:0] deposit_max_reg;
    logic [31:0] deposit_max_next;
    logic [31:0] merged;
    logic [3:0]  lvl1 [4];
    logic [3:0]  lvl2 [2];

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            if (read_word[i*4 +: 4] > deposit_max_reg[i*4 +: 4])
                merged[i*4 +: 4] = read_word[i*4 +: 4];
            else
                merged[i*4 +: 4] = deposit_max_reg[i*4 +: 4];
        end
        deposit_max_next = update ? merged : deposit_max_reg;
    end

    // three-level max tree over the eight nibbles of the updated word
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (deposit_max_next[i*8 +: 4] > deposit_max_next[i*8+4 +: 4])
                lvl1[i] = deposit_max_next[i*8 +: 4];
            else
                lvl1[i] = deposit_max_next[i*8+4 +: 4];
        end
        for (int i = 0; i < 2; i++)
        begin
            lvl2[i] = (lvl1[2*i] > lvl1[2*i+1]) ? lvl1[2*i] : lvl1[2*i+1];
        end
        highest = (lvl2[0] > lvl2[1]) ? lvl2[0] : lvl2[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            deposit_max_reg <= '0;
        else
            deposit_max_reg <= deposit_max_next;
    end

endmodule

// ===== hw/rtl/sprite_collision_buffer_writer.sv =====
// Top level of the sprite collision buffer writer: APB registers, line state
// and result register. Depends on scbw_pkg and scbw_depository.
//
//   channel   direction  handshake                  word
//   item      in         item_valid / item_ready    item_t (kind, address, hpos, ...)
//   result    out        result_valid / result_ready result_t (write, highest)
//   apb       in/out     psel, penable, pready      coll_number, colors, enable
//
// Every accepted word yields exactly one result word, in the cycle after it is accepted.
// One word per cycle while results are taken: all work is shallow logic from the line state and the
// incoming word into the result register.
// item_ready drops only while a result sits unclaimed in the result register.
// rst_n clears line state, depository and registers; no clearing pass.
module sprite_collision_buffer_writer
    import scbw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // item channel
    input  logic              item_valid,
    output logic              item_ready,
    input  item_t             item,
    // result channel
    output logic              result_valid,
    input  logic              result_ready,
    output result_t           result,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [3:0]  coll_number_reg;
    logic [15:0] colliding_colors_reg;
    logic        deposit_enable_reg;
    logic        cfg_write;
    logic [1:0]  reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coll_number_reg      <= '0;
            colliding_colors_reg <= '0;
            deposit_enable_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_COLL_NUMBER:      coll_number_reg      <= pwdata[3:0];
                REG_COLLIDING_COLORS: colliding_colors_reg <= pwdata[15:0];
                REG_DEPOSIT_ENABLE:   deposit_enable_reg   <= pwdata[0];
                default:              ; // unmapped address, write ignored
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_COLL_NUMBER:      prdata = {28'd0, coll_number_reg};
            REG_COLLIDING_COLORS: prdata = {16'd0, colliding_colors_reg};
            REG_DEPOSIT_ENABLE:   prdata = {31'd0, deposit_enable_reg};
            default:              prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: result register frees up when taken, or is empty
    // ------------------------------------------------------------------
    logic    result_valid_reg;
    result_t result_reg;
    result_t result_next;
    logic    accept;

    assign item_ready   = !result_valid_reg || result_ready;
    assign accept       = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // Line state
    // ------------------------------------------------------------------
    logic [15:0] line_base_reg,      line_base_next;
    logic [8:0]  word_offset_reg,    word_offset_next;
    logic        offset_invalid_reg, offset_invalid_next;
    logic [31:0] pending_mask_reg,   pending_mask_next;

    logic [8:0]  pix_offset;
    logic [2:0]  pix_nibble;
    logic [31:0] pix_bits;
    logic        pix_in_line;
    logic        pix_hit;
    logic        moved;
    logic        emit;
    logic        deposit_update;
    logic [3:0]  highest;

    // word offset (hpos & ~7) >> 1; little-endian nibble swap within byte
    assign pix_offset  = {item.hpos[9:3], 2'b00};
    assign pix_nibble  = item.hpos[2:0] ^ 3'd1;
    assign pix_bits    = NIBBLE_MASK << {pix_nibble, 2'b00};
    assign pix_in_line = 32'(item.hpos) < LINE_PIXELS;
    assign pix_hit     = colliding_colors_reg[item.pixel];
    assign moved       = offset_invalid_reg || (pix_offset != word_offset_reg);

    assign deposit_update = accept && (item.kind == KIND_DEPOSIT_READ)
                            && deposit_enable_reg;

    scbw_depository u_depository (
        .clk       (clk),
        .rst_n     (rst_n),
        .update    (deposit_update),
        .read_word (item.read_word),
        .highest   (highest)
    );

    always_comb
    begin
        line_base_next      = line_base_reg;
        word_offset_next    = word_offset_reg;
        offset_invalid_next = offset_invalid_reg;
        pending_mask_next   = pending_mask_reg;
        emit                = 1'b0;

        case (item.kind)
            KIND_NEW_LINE:
            begin
                line_base_next      = item.line_address;
                offset_invalid_next = 1'b1;
                pending_mask_next   = '0;
            end
            KIND_PIXEL:
            begin
                if (pix_in_line)
                begin
                    if (moved)
                    begin
                        // crossing into a new word: write out what is pending
                        emit                = (pending_mask_reg != '0);
                        pending_mask_next   = '0;
                        word_offset_next    = pix_offset;
                        offset_invalid_next = 1'b0;
                    end
                    if (pix_hit)
                        pending_mask_next = pending_mask_next | pix_bits;
                end
            end
            KIND_FLUSH:
            begin
                // mask is kept after a flush
                emit = (pending_mask_reg != '0);
            end
            default:
            begin
                // deposit read: handled in the depository
            end
        endcase

        result_next.write_valid       = emit;
        result_next.write_mask        = emit ? pending_mask_reg : '0;
        result_next.write_address     = emit ? (line_base_reg + {7'd0, word_offset_reg})
                                             : '0;
        result_next.write_data        = emit ? {4{coll_number_reg}} : '0;
        result_next.highest_valid     = deposit_enable_reg;
        result_next.highest_collision = deposit_enable_reg ? highest : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_base_reg      <= '0;
            word_offset_reg    <= '0;
            offset_invalid_reg <= 1'b0;
            pending_mask_reg   <= '0;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                line_base_reg      <= line_base_next;
                word_offset_reg    <= word_offset_next;
                offset_invalid_reg <= offset_invalid_next;
                pending_mask_reg   <= pending_mask_next;
            end
            if (accept)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_write_has_mask: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.write_valid |-> result.write_mask != '0)
        else $error("write issued with empty mask");

    a_idle_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.write_valid |->
            result.write_mask == '0 && result.write_address == '0
            && result.write_data == '0)
        else $error("write fields nonzero without a write");

    a_highest_gated: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.highest_valid |-> result.highest_collision == '0)
        else $error("highest collision reported while depository disabled");

    a_new_line_drops: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.kind == KIND_NEW_LINE |=>
            pending_mask_reg == '0 && offset_invalid_reg)
        else $error("new line did not drop pending mask");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid_reg |-> item_ready)
        else $error("item stalled with empty result register");

endmodule
